/* rtl/core/hcs_pkg.sv */
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants of the Hangul coda splitter
// Job descriptor passed from the front to the back, UTF-8 masks,
// syllable range and the final-consonant jamo table.
// ----------------------------------------------------------------------------
package hcs_pkg;

    // UTF-8 byte classes
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    // Precomposed syllable block
    localparam logic [15:0] SYL_FIRST = 16'hAC00;
    localparam logic [15:0] SYL_LAST  = 16'hD7A3;

    // floor(s / 28) == (s * DIV28_MUL) >> DIV28_SHIFT for every syllable index
    localparam int          SYL_IDX_W   = 14;
    localparam int          QUOT_W      = 9;
    localparam int          DIV28_SHIFT = 18;
    localparam logic [13:0] DIV28_MUL   = 14'd9363;

    // Up to six bytes leave the back for one job
    localparam int MAX_OUT   = 6;
    localparam int OUT_IDX_W = 3;

    typedef enum logic {
        JOB_RAW,   // pass the listed bytes through
        JOB_SYL    // split a syllable, bytes hold its three-byte encoding
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [1:0]              nbytes;   // raw byte count, 1 to 3
        logic [2:0][7:0]         bytes;    // bytes[0] goes out first
        logic [QUOT_W-1:0]       quot;     // syllable index / 28
    } t_job;

    // Compatibility jamo of each final consonant; index zero means none
    function automatic logic [15:0] coda_jamo(input logic [4:0] idx);
        logic [15:0] jamo;
        case (idx)
            5'd1:    jamo = 16'h3131;
            5'd2:    jamo = 16'h3132;
            5'd3:    jamo = 16'h3133;
            5'd4:    jamo = 16'h3134;
            5'd5:    jamo = 16'h3135;
            5'd6:    jamo = 16'h3136;
            5'd7:    jamo = 16'h3137;
            5'd8:    jamo = 16'h3139;
            5'd9:    jamo = 16'h313A;
            5'd10:   jamo = 16'h313B;
            5'd11:   jamo = 16'h313C;
            5'd12:   jamo = 16'h313D;
            5'd13:   jamo = 16'h313E;
            5'd14:   jamo = 16'h313F;
            5'd15:   jamo = 16'h3140;
            5'd16:   jamo = 16'h3141;
            5'd17:   jamo = 16'h3142;
            5'd18:   jamo = 16'h3144;
            5'd19:   jamo = 16'h3145;
            5'd20:   jamo = 16'h3146;
            5'd21:   jamo = 16'h3147;
            5'd22:   jamo = 16'h3148;
            5'd23:   jamo = 16'h314A;
            5'd24:   jamo = 16'h314B;
            5'd25:   jamo = 16'h314C;
            5'd26:   jamo = 16'h314D;
            5'd27:   jamo = 16'h314E;
            default: jamo = 16'h0000;
        endcase
        return jamo;
    endfunction

endpackage

/* rtl/core/hcs_front.sv */
// ----------------------------------------------------------------------------
// hcs_front: byte collector and classifier
// Tracks the UTF-8 sequence in progress and turns each accepted beat
// into at most one job for the back.
// ----------------------------------------------------------------------------
module hcs_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_in_byte,
    output logic        o_stall,
    input  logic        i_q_full,
    output logic        o_push,
    output hcs_pkg::t_job o_job
);
    import hcs_pkg::*;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_ONE,
        HELD_TWO,
        HELD_BAD    // never reached; behaves as nothing held
    } t_held;

    t_held                r_held, n_held;
    logic [7:0]           r_lead, n_lead;
    logic [7:0]           r_second, n_second;
    logic                 n_push;
    t_job                 n_job;

    logic                 accept;
    logic                 is_cont, is_lead3, is_syl;
    logic [15:0]          cp;
    logic [SYL_IDX_W-1:0] syl_idx;
    logic [2*SYL_IDX_W-1:0] prod;

    assign accept   = i_valid && !i_q_full;
    assign o_stall  = i_q_full;
    assign is_cont  = (i_in_byte & CONT_MASK) == CONT_CODE;
    assign is_lead3 = (i_in_byte & LEAD3_MASK) == LEAD3_CODE;
    assign cp       = {r_lead[3:0], r_second[5:0], i_in_byte[5:0]};
    assign is_syl   = (cp >= SYL_FIRST) && (cp <= SYL_LAST);
    assign syl_idx  = SYL_IDX_W'(cp - SYL_FIRST);
    assign prod     = (2*SYL_IDX_W)'(syl_idx) * (2*SYL_IDX_W)'(DIV28_MUL);

    always_comb begin
        n_held   = r_held;
        n_lead   = r_lead;
        n_second = r_second;
        n_push   = 1'b0;
        n_job    = '0;
        n_job.kind = JOB_RAW;
        n_job.quot = QUOT_W'(prod >> DIV28_SHIFT);
        unique case (r_held)
            HELD_ONE: begin
                if (is_cont) begin
                    n_second = i_in_byte;
                    n_held   = HELD_TWO;
                end else begin
                    // broken sequence: flush the lead, restart on a new lead
                    n_push         = 1'b1;
                    n_job.bytes[0] = r_lead;
                    if (is_lead3) begin
                        n_job.nbytes = 2'd1;
                        n_lead       = i_in_byte;
                        n_held       = HELD_ONE;
                    end else begin
                        n_job.nbytes   = 2'd2;
                        n_job.bytes[1] = i_in_byte;
                        n_held         = HELD_NONE;
                    end
                end
            end
            HELD_TWO: begin
                n_push         = 1'b1;
                n_job.bytes[0] = r_lead;
                n_job.bytes[1] = r_second;
                n_job.bytes[2] = i_in_byte;
                if (is_cont) begin
                    n_held       = HELD_NONE;
                    n_job.nbytes = 2'd3;
                    if (is_syl) begin
                        n_job.kind = JOB_SYL;
                    end
                end else if (is_lead3) begin
                    n_job.nbytes = 2'd2;
                    n_lead       = i_in_byte;
                    n_held       = HELD_ONE;
                end else begin
                    n_job.nbytes = 2'd3;
                    n_held       = HELD_NONE;
                end
            end
            default: begin
                if (is_lead3) begin
                    n_lead = i_in_byte;
                    n_held = HELD_ONE;
                end else begin
                    n_push         = 1'b1;
                    n_job.nbytes   = 2'd1;
                    n_job.bytes[0] = i_in_byte;
                    n_held         = HELD_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= HELD_NONE;
            r_lead   <= 8'h00;
            r_second <= 8'h00;
        end else if (accept) begin
            r_held   <= n_held;
            r_lead   <= n_lead;
            r_second <= n_second;
        end
    end

    assign o_push = accept && n_push;
    assign o_job  = n_job;

endmodule

/* rtl/core/hcs_queue.sv */
// ----------------------------------------------------------------------------
// hcs_queue: job queue between front and back
// Small circular buffer; full and non-empty come straight from registers.
// ----------------------------------------------------------------------------
module hcs_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output hcs_pkg::t_job o_job
);
    import hcs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign do_push = i_push && (r_count != FULL_CNT);
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

/* rtl/core/hcs_back.sv */
// ----------------------------------------------------------------------------
// hcs_back: job expander and output register
// Loads a job into a six-byte expansion buffer, splitting syllables on load,
// and drains it one beat per cycle via the output register unless stalled.
// ----------------------------------------------------------------------------
module hcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  hcs_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last
);
    import hcs_pkg::*;

    logic [7:0]           r_bytes [MAX_OUT];
    logic [7:0]           n_bytes [MAX_OUT];
    logic [OUT_IDX_W-1:0] r_cnt, n_cnt;
    logic [OUT_IDX_W-1:0] r_idx;
    logic                 r_busy;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 out_free, emit, at_last, emit_last, pop;
    logic [15:0]          cp, base, jamo;
    logic [SYL_IDX_W-1:0] syl_idx, quot28, rem;
    logic [4:0]           coda;

    // syllable split: coda = index - 28 * (index / 28)
    assign cp      = {i_job.bytes[0][3:0], i_job.bytes[1][5:0], i_job.bytes[2][5:0]};
    assign syl_idx = SYL_IDX_W'(cp - SYL_FIRST);
    assign quot28  = SYL_IDX_W'({i_job.quot, 5'b0}) - SYL_IDX_W'({i_job.quot, 2'b0});
    assign rem     = syl_idx - quot28;
    assign coda    = rem[4:0];
    assign base    = cp - 16'(coda);
    assign jamo    = coda_jamo(coda);

    always_comb begin
        n_bytes[0] = i_job.bytes[0];
        n_bytes[1] = i_job.bytes[1];
        n_bytes[2] = i_job.bytes[2];
        n_bytes[3] = LEAD3_CODE | {4'h0, jamo[15:12]};
        n_bytes[4] = CONT_CODE | {2'b00, jamo[11:6]};
        n_bytes[5] = CONT_CODE | {2'b00, jamo[5:0]};
        n_cnt      = OUT_IDX_W'(i_job.nbytes);
        if (i_job.kind == JOB_SYL) begin
            n_bytes[0] = LEAD3_CODE | {4'h0, base[15:12]};
            n_bytes[1] = CONT_CODE | {2'b00, base[11:6]};
            n_bytes[2] = CONT_CODE | {2'b00, base[5:0]};
            n_cnt      = (coda == 5'd0) ? OUT_IDX_W'(3) : OUT_IDX_W'(MAX_OUT);
        end
    end

    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = r_busy && out_free;
    assign at_last   = (r_idx == r_cnt - 1'b1);
    assign emit_last = emit && at_last;
    assign pop       = i_q_valid && (!r_busy || emit_last);

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_bytes[k] <= n_bytes[k];
            end
            r_cnt <= n_cnt;
        end
        if (emit) begin
            r_out_byte <= r_bytes[r_idx];
            r_out_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_busy <= !at_last;
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

    assign o_pop      = pop;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

endmodule

/* rtl/core/hangul_coda_splitter_utf8.sv */
// ----------------------------------------------------------------------------
// hangul_coda_splitter_utf8: Hangul final-consonant splitter on UTF-8 text
// Collects three-byte UTF-8 sequences, splits each precomposed syllable into
// its open syllable plus the compatibility jamo of its final consonant, and
// passes every other byte through unchanged.
// ----------------------------------------------------------------------------
//
//  channel | valid   | stall   | payload               | one beat
//  --------+---------+---------+-----------------------+--------------------
//  input   | i_valid | o_stall | i_in_byte             | one text byte
//  output  | o_valid | i_stall | o_out_byte,o_run_last | one result byte
//
//  The front takes one input beat per cycle while the job queue has room;
//  o_stall is the queue-full flag and never looks at i_valid.
//  The back drains one output beat per cycle unless stalled, so throughput
//  is set by the output port: a syllable with a final consonant puts out
//  twice as many bytes as it takes in, and plain text one byte per byte.
//  The first output beat reaches the port through the job queue, the
//  expansion buffer and the output register after its input beat is accepted.
//  Synchronous active-low reset empties the queue and drops any held bytes;
//  a held output beat stays on the port unchanged while i_stall is high.
// ----------------------------------------------------------------------------
module hangul_coda_splitter_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import hcs_pkg::*;

    t_job push_job, head_job;
    logic push, q_full, q_valid, pop;

    // Front: hold partial sequences, classify each beat into at most one job
    hcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (push_job)
    );

    // Queue: decouple input acceptance from output back-pressure
    hcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Back: expand a job into bytes and advance them one beat at a time
    hcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule
